// ===== sv/rpa_pkg.sv =====
`default_nettype none

package rpa_pkg;

  // Pool size and fixed field widths
  localparam int NUM_REGS_DEF = 16;
  localparam int MASK_W       = 16;
  localparam int OUT_IDX_W    = 4;
  localparam int CNT_W        = 3;
  localparam int MAX_PARAMS   = 6;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_USED   = 2'd1,
    ST_PARAM  = 2'd2,
    ST_CSFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_FREEALL = 2'd2,
    OP_RESERVE = 2'd3
  } op_t;

  // Decision of the shared status unit for one entry
  typedef struct packed {
    logic    hit;
    logic    wr_en;
    logic    save;
    status_t wr_status;
  } step_res_t;

  // Fixed order in which parameter registers are reserved
  function automatic logic [CNT_W-1:0] param_reg(input logic [CNT_W-1:0] k);
    logic [CNT_W-1:0] r;
    case (k)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rpa_step_unit.sv =====
`default_nettype none

module rpa_step_unit
  import rpa_pkg::*;
(
  input  op_t       op,
  input  status_t   st,
  input  logic      cs,
  output step_res_t res
);

  // Decide hit, write and save for one entry under the current operation
  always_comb begin
    res = '{hit: 1'b0, wr_en: 1'b0, save: 1'b0, wr_status: ST_FREE};
    unique case (op)
      OP_ALLOC: begin
        res.hit       = (st == ST_FREE) || (st == ST_CSFREE);
        res.wr_en     = res.hit;
        res.save      = cs && (st == ST_FREE);
        res.wr_status = ST_USED;
      end
      OP_FREE: begin
        res.hit       = (st == ST_USED);
        res.wr_en     = res.hit;
        res.wr_status = cs ? ST_CSFREE : ST_FREE;
      end
      OP_FREEALL: begin
        res.hit = (st != ST_FREE) && cs;
      end
      OP_RESERVE: begin
        res.hit       = 1'b1;
        res.wr_en     = 1'b1;
        res.wr_status = ST_PARAM;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rpa_status_store.sv =====
`default_nettype none

module rpa_status_store
  import rpa_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF,
  parameter int IDX_W    = $clog2(NUM_REGS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] raddr,
  output status_t          rd_status,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  status_t          wdata,
  input  logic             clear_all
);

  status_t mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  status_t rd_data;
  logic rd_vld;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    rd_vld  <= vld[raddr];
  end

  // Track written entries; reset and free all drop them back to free
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign rd_status = rd_vld ? rd_data : ST_FREE;

endmodule

`default_nettype wire

// ===== sv/register_pool_allocator.sv =====
// Register pool allocator: a two-bit status per register, kept in a small
// memory and worked on one entry at a time by a shared status unit.
// Input channel (in_valid / in_stall) carries operation, reg_index and
// param_count; a word is taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall) carries one result word per
// allocate, free and reserve, and one word per restore (at least one) for
// free all, with last marking the final word of the item.
// Configuration: cfg_valid / cfg_ready / cfg_data writes the callee-saved
// mask; cfg_ready is always high. Write it only while the block is idle.
// Sequence, set by the memory walk (each entry is read, then checked):
//   allocate: scans entries upward from index 0 until the first free one;
//   free: reads one entry and frees it if used (none past the pool);
//   reserve: writes up to min(param_count,6) parameter registers in turn;
//   free all: walks all entries down from the last, pausing on a stall.
// in_stall is high from acceptance until the final word sits in the output
// register; the next item may start while that word still waits.
// While the receiver stalls, the output word holds and a free all walk
// pauses at its next restore.
// Reset (rst, synchronous) marks every register free and clears the mask.
`default_nettype none

module register_pool_allocator
  import rpa_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [3:0]           reg_index,
  input  logic [CNT_W-1:0]     param_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] granted_index,
  output logic                 save_needed,
  output logic                 restore_valid,
  output logic                 out_of_registers,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MASK_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_PARAM = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  op_t op;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] k;
  logic [IDX_W-1:0] addr;
  logic [MASK_W-1:0] cs_mask;

  logic [OUT_IDX_W-1:0] res_idx;
  logic res_save, res_rv, res_oor;
  logic pend_valid;
  logic [IDX_W-1:0] pend_idx;

  status_t rd_status;
  step_res_t step;
  status_t step_st;
  logic cs;
  logic [7:0] addr8;
  logic [CNT_W-1:0] preg;
  logic preg_ok;

  logic emit_ok, load_mid, load_final, accept;
  logic we, clear_all;
  logic [IDX_W-1:0] waddr;
  logic [CNT_W-1:0] cnt_sat;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cs_mask <= cfg_data;
    end
  end

  // Callee-saved bit of the current entry; indexes past the mask never are
  assign addr8 = 8'(addr);
  assign cs    = (addr8 < 8'd16) && cs_mask[addr8[3:0]];

  // Parameter register for the current reserve step
  assign preg    = param_reg(k);
  assign preg_ok = (8'(preg) < 8'(NUM_REGS)) && (k < cnt);

  // Shared status unit: reserve needs no read, others see the stored entry
  assign step_st = (state == S_PARAM) ? ST_FREE : rd_status;

  rpa_step_unit u_step (
    .op  (op),
    .st  (step_st),
    .cs  (cs),
    .res (step)
  );

  // Memory write and bulk clear
  assign we = ((state == S_CHECK) && step.wr_en) || ((state == S_PARAM) && preg_ok);
  assign waddr = (state == S_PARAM) ? IDX_W'(preg) : addr;
  assign clear_all = (state == S_CHECK) && (op == OP_FREEALL) && (addr == '0)
                     && !(step.hit && pend_valid && !emit_ok);

  rpa_status_store #(
    .NUM_REGS (NUM_REGS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .raddr     (addr),
    .rd_status (rd_status),
    .we        (we),
    .waddr     (waddr),
    .wdata     (step.wr_status),
    .clear_all (clear_all)
  );

  // Handshake helpers
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign emit_ok    = !out_valid || !out_stall;
  assign load_final = (state == S_EMIT) && emit_ok;
  assign load_mid   = (state == S_CHECK) && (op == OP_FREEALL) && step.hit
                      && pend_valid && emit_ok;
  assign cnt_sat    = (param_count > CNT_W'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS)
                                                         : param_count;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= op_t'(operation);
            cnt        <= cnt_sat;
            k          <= '0;
            pend_valid <= 1'b0;
            res_idx    <= '0;
            res_save   <= 1'b0;
            res_rv     <= 1'b0;
            res_oor    <= 1'b0;
            unique case (op_t'(operation))
              OP_ALLOC: begin
                addr  <= '0;
                state <= S_READ;
              end
              OP_FREE: begin
                addr  <= IDX_W'(reg_index);
                state <= (8'(reg_index) < 8'(NUM_REGS)) ? S_READ : S_EMIT;
              end
              OP_FREEALL: begin
                addr  <= LAST_IDX;
                state <= S_READ;
              end
              OP_RESERVE: state <= S_PARAM;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          unique case (op)
            OP_ALLOC: begin
              if (step.hit) begin
                res_idx  <= OUT_IDX_W'(addr);
                res_save <= step.save;
                state    <= S_EMIT;
              end else if (addr == LAST_IDX) begin
                res_oor <= 1'b1;
                state   <= S_EMIT;
              end else begin
                addr  <= addr + 1'b1;
                state <= S_READ;
              end
            end
            OP_FREEALL: begin
              if (!(step.hit && pend_valid && !emit_ok)) begin
                // Hold the newest restore until the next one or the end
                if (step.hit) begin
                  pend_valid <= 1'b1;
                  pend_idx   <= addr;
                end
                if (addr == '0) begin
                  res_rv  <= step.hit || pend_valid;
                  res_idx <= step.hit   ? OUT_IDX_W'(addr) :
                             pend_valid ? OUT_IDX_W'(pend_idx) : '0;
                  state   <= S_EMIT;
                end else begin
                  addr  <= addr - 1'b1;
                  state <= S_READ;
                end
              end
            end
            default: state <= S_EMIT;
          endcase
        end
        S_PARAM: begin
          if (k < cnt) begin
            k <= k + 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a word when the slot is free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_final || load_mid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid) begin
      granted_index    <= OUT_IDX_W'(pend_idx);
      save_needed      <= 1'b0;
      restore_valid    <= 1'b1;
      out_of_registers <= 1'b0;
      last             <= 1'b0;
    end else if (load_final) begin
      granted_index    <= res_idx;
      save_needed      <= res_save;
      restore_valid    <= res_rv;
      out_of_registers <= res_oor;
      last             <= 1'b1;
    end
  end

endmodule

`default_nettype wire
